### rtl/alm_pkg.sv
// alm_pkg: shared widths, command and status codes, constants and the cell control word
// for the array list block; no dependencies
package alm_pkg;

    localparam int DEPTH  = 16;
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int SCAN_W = 16;
    localparam int SCAN_IW = $clog2(SCAN_W);

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCATE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic signed [VAL_W-1:0] BAD_READ = -32'sd10000000;

    typedef struct packed {
        logic                    acc;
        logic                    ins;
        logic                    del;
        logic                    loc;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } t_cell_ctrl;

endpackage

### rtl/alm_cell.sv
// alm_cell: one list entry of the cell chain, shifts with its neighbours and compares
// for locate; depends on alm_pkg
module alm_cell #(
    parameter int DEPTH = alm_pkg::DEPTH
) (
    input  logic                            i_clk,
    input  alm_pkg::t_cell_ctrl             i_ctrl,
    input  logic [$clog2(DEPTH)-1:0]        i_idx,
    input  logic [$clog2(DEPTH+1)-1:0]      i_count,
    input  logic signed [alm_pkg::VAL_W-1:0] i_left,
    input  logic signed [alm_pkg::VAL_W-1:0] i_right,
    output logic signed [alm_pkg::VAL_W-1:0] o_value,
    output logic                            o_hit
);

    localparam int CW   = $clog2(DEPTH+1);
    localparam int CMPW = (CW > alm_pkg::POS_W) ? CW : alm_pkg::POS_W;

    logic signed [alm_pkg::VAL_W-1:0] r_value;
    logic signed [alm_pkg::VAL_W-1:0] n_value;
    logic                             r_hit;
    logic                             n_hit;
    logic [CMPW-1:0]                  w_idx;
    logic [CMPW-1:0]                  w_pos;
    logic [CMPW-1:0]                  w_cnt;

    assign w_idx = CMPW'(i_idx);
    assign w_pos = CMPW'(i_ctrl.pos);
    assign w_cnt = CMPW'(i_count);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (w_idx == w_pos) begin
                n_value = i_ctrl.val;
            end else if (w_idx > w_pos && w_idx <= w_cnt) begin
                n_value = i_left;
            end
        end else if (i_ctrl.del) begin
            if (w_idx >= w_pos && (w_idx + CMPW'(1)) < w_cnt) begin
                n_value = i_right;
            end
        end
    end

    assign n_hit = i_ctrl.loc && (w_idx < w_cnt) && (r_value == i_ctrl.val);

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctrl.acc) begin
            r_hit <= n_hit;
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

### rtl/array_list_insert_delete_locate.sv
// array_list_insert_delete_locate: ordered list in a chain of alm_cell entries with a
// stored length, group scanner for locate and an output register; depends on alm_pkg
// sequence: an accepted command updates the cell chain and the state register, and its result
// then loads the output register in S_RES; locate scans one 16-entry group of match bits per cycle
// flow: a single command in flight; a new command is taken only after the last result has loaded
// the output register, which the group scan and i_stall can hold off
// reset: synchronous active low, clears length, control and output valid; entries undefined
module array_list_insert_delete_locate #(
    parameter int DEPTH = alm_pkg::DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [alm_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [alm_pkg::VAL_W-1:0]  i_value,
    input  logic [alm_pkg::POS_W-1:0]         i_position,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [alm_pkg::STAT_W-1:0]        o_status,
    output logic [alm_pkg::POS_W-1:0]         o_found_position,
    output logic signed [alm_pkg::VAL_W-1:0]  o_read_value,
    output logic [alm_pkg::POS_W-1:0]         o_length
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH+1);
    localparam int CMPW = (CW > alm_pkg::POS_W) ? CW : alm_pkg::POS_W;
    localparam int NGRP = (DEPTH + alm_pkg::SCAN_W - 1) / alm_pkg::SCAN_W;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int HW   = NGRP * alm_pkg::SCAN_W;
    localparam int SW   = GW + alm_pkg::SCAN_IW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RES  = 1'b1;

    logic                             r_state;
    logic                             n_state;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [alm_pkg::CMD_W-1:0]        r_cmd;
    logic [alm_pkg::POS_W-1:0]        r_pos;
    logic [alm_pkg::STAT_W-1:0]       r_stat;
    logic [alm_pkg::STAT_W-1:0]       n_stat;
    logic [GW-1:0]                    r_grp;
    logic                             r_out_valid;
    logic [alm_pkg::STAT_W-1:0]       r_out_status;
    logic [alm_pkg::POS_W-1:0]        r_out_found;
    logic signed [alm_pkg::VAL_W-1:0] r_out_read;
    logic [alm_pkg::POS_W-1:0]        r_out_length;

    logic                             w_accept;
    logic                             w_full;
    logic                             w_ins_ok;
    logic                             w_del_ok;
    logic [CMPW-1:0]                  w_pos_e;
    logic [CMPW-1:0]                  w_cnt_e;
    alm_pkg::t_cell_ctrl              w_ctrl;
    logic signed [alm_pkg::VAL_W-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]                 w_hit;
    logic [HW-1:0]                    w_hit_pad;
    logic [alm_pkg::SCAN_W-1:0]       w_grp_hits;
    logic [alm_pkg::SCAN_IW-1:0]      w_enc;
    logic                             w_any;
    logic                             w_last_grp;
    logic                             w_ready;
    logic                             w_load;
    logic [SW-1:0]                    w_found_full;
    logic [alm_pkg::POS_W-1:0]        w_found;
    logic signed [alm_pkg::VAL_W-1:0] w_read;
    logic [CMPW-1:0]                  w_rpos_e;
    logic [IW-1:0]                    w_rd_idx;

    // input side
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_pos_e  = CMPW'(i_position);
    assign w_cnt_e  = CMPW'(r_count);
    assign w_full   = (w_cnt_e >= CMPW'(DEPTH));
    assign w_ins_ok = (i_cmd == alm_pkg::CMD_INSERT) && !w_full && (w_pos_e <= w_cnt_e);
    assign w_del_ok = (i_cmd == alm_pkg::CMD_DELETE) && (w_pos_e < w_cnt_e);

    always_comb begin
        n_stat = alm_pkg::ST_OK;
        unique case (i_cmd)
            alm_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_stat = alm_pkg::ST_FULL;
                end else if (w_pos_e > w_cnt_e) begin
                    n_stat = alm_pkg::ST_RANGE;
                end
            end
            alm_pkg::CMD_DELETE, alm_pkg::CMD_RETRIEVE: begin
                if (w_pos_e >= w_cnt_e) begin
                    n_stat = alm_pkg::ST_RANGE;
                end
            end
            default: begin
                n_stat = alm_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_accept && w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_accept && w_del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        w_ctrl.acc = w_accept;
        w_ctrl.ins = w_accept && w_ins_ok;
        w_ctrl.del = w_accept && w_del_ok;
        w_ctrl.loc = w_accept && (i_cmd == alm_pkg::CMD_LOCATE);
        w_ctrl.pos = i_position;
        w_ctrl.val = i_value;
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [alm_pkg::VAL_W-1:0] w_left;
            logic signed [alm_pkg::VAL_W-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_value[gi-1];
            end
            if (gi == DEPTH-1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_value[gi+1];
            end
            alm_cell #(
                .DEPTH (DEPTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_idx   (IW'(gi)),
                .i_count (r_count),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_value[gi]),
                .o_hit   (w_hit[gi])
            );
        end
        for (gi = 0; gi < HW; gi++) begin : g_pad
            if (gi < DEPTH) begin : g_real
                assign w_hit_pad[gi] = w_hit[gi];
            end else begin : g_zero
                assign w_hit_pad[gi] = 1'b0;
            end
        end
    endgenerate

    // locate scan, one group a cycle
    assign w_grp_hits = w_hit_pad[r_grp*alm_pkg::SCAN_W +: alm_pkg::SCAN_W];

    always_comb begin
        w_enc = '0;
        for (int k = alm_pkg::SCAN_W - 1; k >= 0; k--) begin
            if (w_grp_hits[k]) begin
                w_enc = alm_pkg::SCAN_IW'(k);
            end
        end
    end

    assign w_any        = |w_grp_hits;
    assign w_last_grp   = (r_grp == GW'(NGRP - 1));
    assign w_found_full = {r_grp, w_enc};
    assign w_ready      = (r_cmd != alm_pkg::CMD_LOCATE) || w_any || w_last_grp;
    assign w_load       = (r_state == S_RES) && w_ready && (!r_out_valid || !i_stall);

    always_comb begin
        w_found = '0;
        if (r_cmd == alm_pkg::CMD_LOCATE) begin
            w_found = w_any ? alm_pkg::POS_W'(w_found_full) : alm_pkg::POS_W'(r_count);
        end
    end

    // retrieve read
    assign w_rpos_e = CMPW'(r_pos);
    assign w_rd_idx = w_rpos_e[IW-1:0];

    always_comb begin
        w_read = '0;
        if (r_cmd == alm_pkg::CMD_RETRIEVE) begin
            w_read = (r_stat == alm_pkg::ST_RANGE) ? alm_pkg::BAD_READ : w_value[w_rd_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_grp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_accept) begin
                r_grp <= '0;
            end else if (r_state == S_RES && !w_ready) begin
                r_grp <= r_grp + GW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_pos  <= i_position;
            r_stat <= n_stat;
        end
        if (w_load) begin
            r_out_status <= r_stat;
            r_out_found  <= w_found;
            r_out_read   <= w_read;
            r_out_length <= alm_pkg::POS_W'(r_count);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_read_value     = r_out_read;
    assign o_length         = r_out_length;

endmodule
